// ===== hdl/hti_pkg.sv =====
`timescale 1ns / 1ps

package hti_pkg;

	// Sizes and widths
	localparam int MAX_WIDTH_DEF = 4096;
	localparam int PIX_W         = 8;
	localparam int ROW_W         = 16;
	localparam int COL_OUT_W     = 12;
	localparam int IMG_W_W       = 13;
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = 16;
	localparam int OUT_DATA_W    = 40;
	localparam int PAD_W         = OUT_DATA_W - PIX_W - ROW_W - COL_OUT_W;

	// Levels and register reset values
	localparam logic [PIX_W-1:0]   PIX_MAX   = 8'd255;
	localparam logic [PIX_W-1:0]   LOW_RST   = 8'd50;
	localparam logic [PIX_W-1:0]   HIGH_RST  = 8'd150;
	localparam logic [IMG_W_W-1:0] IMG_W_RST = 13'd640;
	localparam logic [ROW_W-1:0]   IMG_H_RST = 16'd480;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LOW_THR    = 2'd0,
		REG_HIGH_THR   = 2'd1,
		REG_IMG_WIDTH  = 2'd2,
		REG_IMG_HEIGHT = 2'd3
	} cfg_reg_t;

	// First-pass class codes held in the line buffer
	typedef enum logic [1:0] {
		CODE_ZERO   = 2'd0,
		CODE_WEAK   = 2'd1,
		CODE_STRONG = 2'd2
	} code_t;

	// Per-item control flags decided at the input
	typedef struct packed {
		logic first;      // releases the pixel up and to the left
		logic second;     // releases itself (last column or last row)
		logic end_row;    // last column of the row
		logic interior;   // released pixel is off the top and left borders
		logic wr_res;     // resolved row buffer is written for this item
		logic sel_tail0;  // column two before the end of the row
		logic sel_tail1;  // last column
	} item_flags_t;

	// One result
	typedef struct packed {
		logic [COL_OUT_W-1:0] col;
		logic [ROW_W-1:0]     row;
		logic [PIX_W-1:0]     pixel;
	} result_t;

	function automatic logic [PIX_W-1:0] weak_level(input logic [PIX_W-1:0] lo,
			input logic [PIX_W-1:0] hi);
		logic [PIX_W:0] sum;
		sum = {1'b0, lo} + {1'b0, hi};
		return sum[PIX_W:1];
	endfunction

	function automatic logic [PIX_W-1:0] code_level(input code_t code,
			input logic [PIX_W-1:0] weak_lvl);
		logic [PIX_W-1:0] lvl;
		case (code)
			CODE_STRONG: lvl = PIX_MAX;
			CODE_WEAK:   lvl = weak_lvl;
			default:     lvl = '0;
		endcase
		return lvl;
	endfunction

	function automatic logic is_strong(input code_t code, input logic [PIX_W-1:0] weak_lvl);
		return code_level(code, weak_lvl) == PIX_MAX;
	endfunction

	function automatic code_t classify(input logic [PIX_W-1:0] pix,
			input logic [PIX_W-1:0] lo, input logic [PIX_W-1:0] hi);
		code_t code;
		priority if (pix < lo) begin
			code = CODE_ZERO;
		end else if (pix > hi) begin
			code = CODE_STRONG;
		end else begin
			code = CODE_WEAK;
		end
		return code;
	endfunction

endpackage

// ===== hdl/hti_cfg.sv =====
`timescale 1ns / 1ps

module hti_cfg
	import hti_pkg::*;
#(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF,
	localparam int WW = $clog2(MAX_WIDTH) + 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic [PIX_W-1:0]      low_thr,
	output logic [PIX_W-1:0]      high_thr,
	output logic [WW-1:0]         eff_w,
	output logic [ROW_W-1:0]      eff_h
);

	logic [PIX_W-1:0]   low_q;
	logic [PIX_W-1:0]   high_q;
	logic [IMG_W_W-1:0] img_w_q;
	logic [ROW_W-1:0]   img_h_q;

	// Register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q   <= LOW_RST;
			high_q  <= HIGH_RST;
			img_w_q <= IMG_W_RST;
			img_h_q <= IMG_H_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_LOW_THR:    low_q   <= cfg_data[PIX_W-1:0];
				REG_HIGH_THR:   high_q  <= cfg_data[PIX_W-1:0];
				REG_IMG_WIDTH:  img_w_q <= cfg_data[IMG_W_W-1:0];
				REG_IMG_HEIGHT: img_h_q <= cfg_data[ROW_W-1:0];
			endcase
		end
	end

	// Sizes in force: zero acts as one, width clamps to the line buffer
	always_comb begin
		priority if (img_w_q == '0) begin
			eff_w = WW'(1);
		end else if (32'(img_w_q) > 32'(MAX_WIDTH)) begin
			eff_w = WW'(MAX_WIDTH);
		end else begin
			eff_w = WW'(img_w_q);
		end
	end

	assign eff_h    = (img_h_q == '0) ? ROW_W'(1) : img_h_q;
	assign low_thr  = low_q;
	assign high_thr = high_q;

endmodule

// ===== hdl/hti_scan.sv =====
`timescale 1ns / 1ps

module hti_scan
	import hti_pkg::*;
#(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF,
	localparam int CW = $clog2(MAX_WIDTH),
	localparam int WW = CW + 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [PIX_W-1:0] in_pixel,
	output logic             in_ready,
	input  logic [PIX_W-1:0] low_thr,
	input  logic [PIX_W-1:0] high_thr,
	input  logic [WW-1:0]    eff_w,
	input  logic [ROW_W-1:0] eff_h,
	input  logic             advance,
	output logic             accept,
	output logic [CW-1:0]    acc_col,
	output logic             s1_valid,
	output code_t            code_s1,
	output code_t            above_s1,
	output logic [ROW_W-1:0] row_s1,
	output logic [CW-1:0]    col_s1,
	output item_flags_t      flags_s1
);

	localparam int CLASS_DEPTH = 2 * (2 ** CW);

	logic [ROW_W-1:0] row_q, row_cur, row_nxt;
	logic [CW-1:0]    col_q, col_cur, col_nxt;
	logic             outside, last_col, last_row;
	code_t            code_cur;
	item_flags_t      flags_cur;

	// Two rows of class codes, banked by row parity
	code_t class_mem [CLASS_DEPTH];

	// Position of this pixel; a size change that leaves it outside starts a new image
	assign outside = ({1'b0, col_q} >= eff_w) || (row_q >= eff_h);
	assign row_cur = outside ? '0 : row_q;
	assign col_cur = outside ? '0 : col_q;
	assign last_col = ({1'b0, col_cur} == eff_w - WW'(1));
	assign last_row = (row_cur == eff_h - ROW_W'(1));

	assign code_cur = classify(in_pixel, low_thr, high_thr);

	always_comb begin
		flags_cur.first     = (row_cur != '0) && (col_cur != '0);
		flags_cur.second    = last_col || last_row;
		flags_cur.end_row   = last_col;
		flags_cur.interior  = (row_cur[ROW_W-1:1] != '0) && (col_cur[CW-1:1] != '0);
		flags_cur.wr_res    = (row_cur != '0) && (col_cur[CW-1:1] != '0);
		flags_cur.sel_tail0 = ({1'b0, col_cur} + WW'(2) == eff_w);
		flags_cur.sel_tail1 = last_col;
	end

	// Raster step
	always_comb begin
		if (last_col) begin
			col_nxt = '0;
			row_nxt = last_row ? '0 : row_cur + ROW_W'(1);
		end else begin
			col_nxt = col_cur + CW'(1);
			row_nxt = row_cur;
		end
	end

	assign in_ready = !s1_valid || advance;
	assign accept   = in_valid && in_ready;
	assign acc_col  = col_cur;

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
			row_q    <= '0;
			col_q    <= '0;
		end else begin
			if (accept) begin
				s1_valid <= 1'b1;
				row_q    <= row_nxt;
				col_q    <= col_nxt;
			end else if (advance) begin
				s1_valid <= 1'b0;
			end
		end
	end

	// Line buffer write of this row, read of the row above, and the stage register
	always_ff @(posedge clk) begin
		if (accept) begin
			class_mem[{row_cur[0], col_cur}] <= code_cur;
			above_s1 <= class_mem[{~row_cur[0], col_cur}];
			code_s1  <= code_cur;
			row_s1   <= row_cur;
			col_s1   <= col_cur;
			flags_s1 <= flags_cur;
		end
	end

endmodule

// ===== hdl/hti_resolve.sv =====
`timescale 1ns / 1ps

module hti_resolve
	import hti_pkg::*;
#(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF,
	localparam int CW = $clog2(MAX_WIDTH)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  logic [CW-1:0]    acc_col,
	input  logic             advance,
	input  logic [PIX_W-1:0] low_thr,
	input  logic [PIX_W-1:0] high_thr,
	input  code_t            code_s1,
	input  code_t            above_s1,
	input  logic [ROW_W-1:0] row_s1,
	input  logic [CW-1:0]    col_s1,
	input  item_flags_t      flags_s1,
	output result_t          res_a,
	output result_t          res_b,
	output logic             has_a,
	output logic             has_b
);

	localparam int RES_DEPTH = 2 ** CW;

	// Resolved-strong bits of the row above the released pixel
	logic res_mem [RES_DEPTH];

	logic             res_rd_s1, byp_s1, byp_bit_s1;
	logic             left_q, tail0_q, tail1_q;
	logic             res_m1_q, res_m2_q;
	code_t            above_m1_q, cur_m1_q, cur_m2_q;
	logic             wr_en;
	logic [CW-1:0]    wr_addr;
	logic [CW-1:0]    col_prev;
	logic [PIX_W-1:0] weak_lvl, first_lvl, resolved;
	logic             res_c, any_strong, is_mid, resolved_strong;

	// Column two to the left takes the left neighbour's resolved bit
	assign wr_en   = advance && flags_s1.wr_res;
	assign wr_addr = col_s1 - CW'(2);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			res_mem[wr_addr] <= left_q;
		end
		if (accept) begin
			res_rd_s1  <= res_mem[acc_col];
			byp_s1     <= wr_en && (wr_addr == acc_col);
			byp_bit_s1 <= left_q;
		end
	end

	// Upper-right neighbour: last two columns live in the tail registers
	always_comb begin
		priority if (flags_s1.sel_tail1) begin
			res_c = tail1_q;
		end else if (flags_s1.sel_tail0) begin
			res_c = tail0_q;
		end else if (byp_s1) begin
			res_c = byp_bit_s1;
		end else begin
			res_c = res_rd_s1;
		end
	end

	// Resolve the pixel up and to the left
	assign weak_lvl  = weak_level(low_thr, high_thr);
	assign first_lvl = code_level(above_m1_q, weak_lvl);
	assign any_strong = res_m2_q || res_m1_q || res_c || left_q ||
		is_strong(above_s1, weak_lvl) || is_strong(cur_m2_q, weak_lvl) ||
		is_strong(cur_m1_q, weak_lvl) || is_strong(code_s1, weak_lvl);
	assign is_mid = flags_s1.interior && (first_lvl < high_thr) && (first_lvl > low_thr);
	assign resolved = is_mid ? (any_strong ? PIX_MAX : '0) : first_lvl;
	assign resolved_strong = (resolved == PIX_MAX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= 1'b0;
		end else if (advance && flags_s1.first) begin
			left_q <= resolved_strong;
		end
	end

	// Neighbour window and end-of-row tail
	always_ff @(posedge clk) begin
		if (advance) begin
			above_m1_q <= above_s1;
			cur_m2_q   <= cur_m1_q;
			cur_m1_q   <= code_s1;
			res_m2_q   <= res_m1_q;
			res_m1_q   <= res_c;
			if (flags_s1.first && flags_s1.end_row) begin
				tail0_q <= resolved_strong;
				tail1_q <= is_strong(above_s1, weak_lvl);
			end
		end
	end

	// Results
	assign col_prev = col_s1 - CW'(1);

	always_comb begin
		res_a.pixel = resolved;
		res_a.row   = row_s1 - ROW_W'(1);
		res_a.col   = COL_OUT_W'(col_prev);
		res_b.pixel = code_level(code_s1, weak_lvl);
		res_b.row   = row_s1;
		res_b.col   = COL_OUT_W'(col_s1);
	end

	assign has_a = flags_s1.first;
	assign has_b = flags_s1.second;

endmodule

// ===== hdl/hti_outbuf.sv =====
`timescale 1ns / 1ps

module hti_outbuf
	import hti_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load,
	input  result_t               res_a,
	input  result_t               res_b,
	input  logic                  has_a,
	input  logic                  has_b,
	output logic                  free,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,
	output logic                  m_tlast
);

	logic    a_v_q, b_v_q;
	result_t a_q, b_q, shown;
	logic    xfer;

	// Slot A goes out before slot B
	assign m_tvalid = a_v_q || b_v_q;
	assign shown    = a_v_q ? a_q : b_q;
	assign m_tlast  = a_v_q ? !b_v_q : 1'b1;
	assign m_tdata  = {{PAD_W{1'b0}}, shown.col, shown.row, shown.pixel};
	assign xfer     = m_tvalid && m_tready;
	assign free     = !m_tvalid || (xfer && m_tlast);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_v_q <= 1'b0;
			b_v_q <= 1'b0;
		end else if (load) begin
			a_v_q <= has_a;
			b_v_q <= has_b;
		end else if (xfer) begin
			if (a_v_q) begin
				a_v_q <= 1'b0;
			end else begin
				b_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			a_q <= res_a;
			b_q <= res_b;
		end
	end

endmodule

// ===== hdl/hysteresis_threshold_image.sv =====
`timescale 1ns / 1ps
// Hysteresis thresholding of an 8-bit gray image streamed in raster order.
// s_axis: one pixel per transfer (tdata = pixel_in). m_axis: one result per
// transfer, tdata = pixel_out, out_row, out_column from the low bit up, tlast
// marks the last result released by one input pixel. cfg_*: thresholds and
// image size, written while the block is idle.
// A pixel (r,c) off the last row and column is released by the arrival of
// pixel (r+1,c+1); pixels in the last row or column are released on arrival,
// after any delayed pixel released by the same input.
// A pixel is registered in the input stage; the results it releases are
// loaded into the output register once it is free. Throughput: one pixel
// per clock while m_axis is ready and no pixel releases two results; a pixel
// with two results holds the input stage until the output register sends both.
// Reset: thresholds 50/150, image 640x480, position at row 0, column 0; the
// line buffers are not cleared and are only read where already written.
// When m_axis stalls, results hold in the output register, one further pixel
// is taken into the input stage, then s_axis_tready falls.
module hysteresis_threshold_image
	import hti_pkg::*;
#(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [PIX_W-1:0]      s_axis_tdata,   // [7:0] pixel_in
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [7:0] pixel_out, [23:8] out_row,
	                                              // [35:24] out_column, [39:36] zero
	output logic                  m_axis_tlast    // last_of_run
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = CW + 1;

	logic [PIX_W-1:0] low_thr, high_thr;
	logic [WW-1:0]    eff_w;
	logic [ROW_W-1:0] eff_h;
	logic             accept, advance, s1_valid, out_free;
	logic [CW-1:0]    acc_col, col_s1;
	code_t            code_s1, above_s1;
	logic [ROW_W-1:0] row_s1;
	item_flags_t      flags_s1;
	result_t          res_a, res_b;
	logic             has_a, has_b;

	// The input stage moves on once the output register can take its results
	assign advance = s1_valid && out_free;

	hti_cfg #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.low_thr   (low_thr),
		.high_thr  (high_thr),
		.eff_w     (eff_w),
		.eff_h     (eff_h)
	);

	hti_scan #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_pixel (s_axis_tdata),
		.in_ready (s_axis_tready),
		.low_thr  (low_thr),
		.high_thr (high_thr),
		.eff_w    (eff_w),
		.eff_h    (eff_h),
		.advance  (advance),
		.accept   (accept),
		.acc_col  (acc_col),
		.s1_valid (s1_valid),
		.code_s1  (code_s1),
		.above_s1 (above_s1),
		.row_s1   (row_s1),
		.col_s1   (col_s1),
		.flags_s1 (flags_s1)
	);

	hti_resolve #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_resolve (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.acc_col  (acc_col),
		.advance  (advance),
		.low_thr  (low_thr),
		.high_thr (high_thr),
		.code_s1  (code_s1),
		.above_s1 (above_s1),
		.row_s1   (row_s1),
		.col_s1   (col_s1),
		.flags_s1 (flags_s1),
		.res_a    (res_a),
		.res_b    (res_b),
		.has_a    (has_a),
		.has_b    (has_b)
	);

	hti_outbuf u_outbuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance),
		.res_a    (res_a),
		.res_b    (res_b),
		.has_a    (has_a),
		.has_b    (has_b),
		.free     (out_free),
		.m_tvalid (m_axis_tvalid),
		.m_tready (m_axis_tready),
		.m_tdata  (m_axis_tdata),
		.m_tlast  (m_axis_tlast)
	);

endmodule

// ===== hdl/hti_checker.sv =====
`timescale 1ns / 1ps

module hti_checker
	import hti_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_axis_tready,
	input logic                  m_axis_tvalid,
	input logic                  m_axis_tready,
	input logic [OUT_DATA_W-1:0] m_axis_tdata,
	input logic                  m_axis_tlast
);

	// A stalled result stays offered
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result withdrawn while stalled");

	// A stalled result keeps its payload
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("result changed while stalled");

	// Padding above the coordinates is zero
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[OUT_DATA_W-1:OUT_DATA_W-PAD_W] == '0)
		else $error("tdata padding not zero");

	// At most two results per pixel: a non-last transfer is followed by the last one
	a_pair: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid && m_axis_tlast)
		else $error("second result of a pixel missing");

	// An empty output register never holds off the input
	a_no_block: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with output empty");

endmodule

bind hysteresis_threshold_image hti_checker u_checker (.*);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import hti_pkg::*;

	localparam int LINE_MAX      = MAX_WIDTH_DEF;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int RANDOM_PIXELS = 1800;
	localparam int WIDE_PIXELS   = 128;
	localparam int HOLD_CYCLES   = 300;
	localparam int SETTLE_CYCLES = 8;
	localparam int SHOWN_ERRORS  = 10;

	// One released pixel as it should leave the block
	typedef struct {
		logic [PIX_W-1:0]     pixel;
		logic [ROW_W-1:0]     row;
		logic [COL_OUT_W-1:0] col;
		logic                 last;
	} pixel_result_t;

	// Directed stimulus: a register write or a pixel, optionally with a fixed answer
	typedef struct {
		bit               is_write;
		cfg_reg_t         reg_idx;
		int               value;
		bit               fixed;
		logic [PIX_W-1:0] fixed_pixel;
	} stim_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = REG_LOW_THR;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [PIX_W-1:0]      s_axis_tdata = '0;   // [7:0] pixel_in
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;        // [7:0] pixel_out, [23:8] out_row,
	                                            // [35:24] out_column, [39:36] zero
	logic                  m_axis_tlast;        // last_of_run

	hysteresis_threshold_image DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Mirror of the thresholding state
	code_t                class_mem [0:2*LINE_MAX-1];
	bit                   strong_row [0:LINE_MAX-1];
	bit                   left_strong = 1'b0;
	int                   at_row = 0;
	int                   at_col = 0;
	logic [PIX_W-1:0]     thr_low = LOW_RST;
	logic [PIX_W-1:0]     thr_high = HIGH_RST;
	logic [IMG_W_W-1:0]   width_reg = IMG_W_RST;
	logic [ROW_W-1:0]     height_reg = IMG_H_RST;

	pixel_result_t fresh [2];
	int            fresh_n;
	pixel_result_t due_pixels [$];
	pixel_result_t want;
	result_t       shown;

	int error_count = 0;
	int cycle_count = 0;
	int burst_left = 0;
	bit gappy = 1'b0;
	bit hold_ask = 1'b0;
	int hold_left = 0;
	int pat_step = 0;
	logic [15:0] stall_pat = 16'hFFFF;

	stim_row_t directed_steps [0:34] = '{
		// 1x1 image from zero sizes, reset thresholds 50/150
		'{1, REG_IMG_WIDTH,  0,   0, 8'd0},
		'{1, REG_IMG_HEIGHT, 0,   0, 8'd0},
		'{0, REG_LOW_THR,    0,   1, 8'd0},
		'{0, REG_LOW_THR,    49,  1, 8'd0},
		'{0, REG_LOW_THR,    50,  1, 8'd100},
		'{0, REG_LOW_THR,    100, 1, 8'd100},
		'{0, REG_LOW_THR,    150, 1, 8'd100},
		'{0, REG_LOW_THR,    151, 1, 8'd255},
		'{0, REG_LOW_THR,    255, 1, 8'd255},
		// crossed thresholds: below-low test wins
		'{1, REG_LOW_THR,    200, 0, 8'd0},
		'{1, REG_HIGH_THR,   100, 0, 8'd0},
		'{0, REG_LOW_THR,    150, 1, 8'd0},
		'{0, REG_LOW_THR,    250, 1, 8'd255},
		'{0, REG_LOW_THR,    100, 1, 8'd0},
		// both thresholds at the top: weak level is full scale
		'{1, REG_LOW_THR,    255, 0, 8'd0},
		'{1, REG_HIGH_THR,   255, 0, 8'd0},
		'{0, REG_LOW_THR,    255, 1, 8'd255},
		'{0, REG_LOW_THR,    254, 1, 8'd0},
		// both thresholds at zero
		'{1, REG_LOW_THR,    0,   0, 8'd0},
		'{1, REG_HIGH_THR,   0,   0, 8'd0},
		'{0, REG_LOW_THR,    0,   1, 8'd0},
		'{0, REG_LOW_THR,    1,   1, 8'd255},
		// 3x3 image, weak centre pulled up by the strong corner below right
		'{1, REG_LOW_THR,    60,  0, 8'd0},
		'{1, REG_HIGH_THR,   180, 0, 8'd0},
		'{1, REG_IMG_WIDTH,  3,   0, 8'd0},
		'{1, REG_IMG_HEIGHT, 3,   0, 8'd0},
		'{0, REG_LOW_THR,    10,  0, 8'd0},
		'{0, REG_LOW_THR,    10,  0, 8'd0},
		'{0, REG_LOW_THR,    10,  0, 8'd0},
		'{0, REG_LOW_THR,    10,  0, 8'd0},
		'{0, REG_LOW_THR,    100, 0, 8'd0},
		'{0, REG_LOW_THR,    10,  0, 8'd0},
		'{0, REG_LOW_THR,    10,  0, 8'd0},
		'{0, REG_LOW_THR,    10,  0, 8'd0},
		'{0, REG_LOW_THR,    200, 0, 8'd0}
	};

	function automatic int eff_width_of(input logic [IMG_W_W-1:0] raw);
		if (raw == 0) return 1;
		if (raw > LINE_MAX) return LINE_MAX;
		return int'(raw);
	endfunction

	function automatic int eff_height_of(input logic [ROW_W-1:0] raw);
		return (raw == 0) ? 1 : int'(raw);
	endfunction

	function automatic logic [PIX_W-1:0] level_of(input code_t cd);
		logic [PIX_W:0] sum;
		sum = {1'b0, thr_low} + {1'b0, thr_high};
		if (cd == CODE_STRONG) return PIX_MAX;
		if (cd == CODE_WEAK) return sum[PIX_W:1];
		return '0;
	endfunction

	function automatic bit class_strong(input int r, input int c);
		return level_of(class_mem[(r % 2) * LINE_MAX + c]) == PIX_MAX;
	endfunction

	// Final value of pixel (p,q); keeps the resolved-row buffer and left bit current
	function automatic logic [PIX_W-1:0] resolve_pixel(input int p, input int q, input int w);
		logic [PIX_W-1:0] lvl;
		logic [PIX_W-1:0] outv;
		bit hit;
		lvl = level_of(class_mem[(p % 2) * LINE_MAX + q]);
		outv = lvl;
		if (p != 0 && q != 0 && lvl < thr_high && lvl > thr_low) begin
			hit = strong_row[q-1] || strong_row[q] || strong_row[q+1] || left_strong ||
				class_strong(p, q + 1) || class_strong(p + 1, q - 1) ||
				class_strong(p + 1, q) || class_strong(p + 1, q + 1);
			outv = hit ? PIX_MAX : '0;
		end
		if (q >= 1) strong_row[q-1] = left_strong;
		left_strong = (outv == PIX_MAX);
		if (q + 2 == w) begin
			strong_row[q] = left_strong;
			strong_row[q+1] = class_strong(p, q + 1);
		end
		return outv;
	endfunction

	// Takes one pixel; leaves the pixels it releases in fresh[0 .. fresh_n-1]
	function automatic void step_image(input logic [PIX_W-1:0] pix);
		int w;
		int h;
		int r;
		int c;
		code_t cd;
		w = eff_width_of(width_reg);
		h = eff_height_of(height_reg);
		if (at_col >= w || at_row >= h) begin
			at_row = 0;
			at_col = 0;
			left_strong = 1'b0;
		end
		r = at_row;
		c = at_col;
		if (pix < thr_low) cd = CODE_ZERO;
		else if (pix > thr_high) cd = CODE_STRONG;
		else cd = CODE_WEAK;
		class_mem[(r % 2) * LINE_MAX + c] = cd;
		fresh_n = 0;
		if (r >= 1 && c >= 1) begin
			fresh[0] = '{resolve_pixel(r - 1, c - 1, w), ROW_W'(r - 1), COL_OUT_W'(c - 1), 1'b0};
			fresh_n = 1;
		end
		if (c + 1 == w || r + 1 == h) begin
			fresh[fresh_n] = '{level_of(cd), ROW_W'(r), COL_OUT_W'(c), 1'b0};
			fresh_n++;
		end
		if (fresh_n > 0) fresh[fresh_n-1].last = 1'b1;
		c++;
		if (c >= w) begin
			c = 0;
			r++;
			if (r >= h) r = 0;
		end
		at_row = r;
		at_col = c;
	endfunction

	// Mostly pixels around the thresholds so weak runs form; else uniform
	function automatic logic [PIX_W-1:0] pick_pixel(input bit near);
		int roll;
		if (!near) return PIX_W'($urandom_range(0, 255));
		roll = $urandom_range(0, 99);
		if (roll < 55 && thr_low <= thr_high) return PIX_W'($urandom_range(thr_low, thr_high));
		if (roll < 85) return (thr_low == 0) ? 8'd0 : PIX_W'($urandom_range(0, thr_low - 1));
		return (thr_high == PIX_MAX) ? PIX_MAX : PIX_W'($urandom_range(thr_high + 1, 255));
	endfunction

	function automatic void flag_error(input string msg);
		error_count++;
		if (error_count <= SHOWN_ERRORS) $display("%s", msg);
	endfunction

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] word);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = word;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			REG_LOW_THR:    thr_low = word[PIX_W-1:0];
			REG_HIGH_THR:   thr_high = word[PIX_W-1:0];
			REG_IMG_WIDTH:  width_reg = word[IMG_W_W-1:0];
			REG_IMG_HEIGHT: height_reg = word[ROW_W-1:0];
		endcase
	endtask

	// Offer one pixel in bursts with gaps; record what it releases once transferred
	task automatic send_pixel(input logic [PIX_W-1:0] pix, input bit fixed,
			input logic [PIX_W-1:0] fixed_px);
		int gap;
		int k;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 32);
			gap = gappy ? $urandom_range(0, 12) : 0;
			if (gap > 0) begin
				@(negedge clk);
				s_axis_tvalid = 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		s_axis_tvalid = 1'b1;
		s_axis_tdata = pix;
		@(posedge clk);
		while (s_axis_tready !== 1'b1) @(posedge clk);
		step_image(pix);
		if (fixed) begin
			due_pixels.push_back('{fixed_px, '0, '0, 1'b1});
		end else begin
			for (k = 0; k < fresh_n; k++) due_pixels.push_back(fresh[k]);
		end
	endtask

	// Stop offering and let every outstanding pixel come out, plus pipeline slack
	task automatic wait_drained();
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		while (due_pixels.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Output side: rotating stall pattern, plus an occasional long hold-off
	always @(negedge clk) begin
		pat_step++;
		if (pat_step % 64 == 0) stall_pat = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
		if (hold_ask) begin
			hold_ask = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready = 1'b0;
		end else begin
			m_axis_tready = stall_pat[pat_step % 16];
		end
	end

	// Compare each output transfer against the oldest outstanding pixel
	assign shown = m_axis_tdata[OUT_DATA_W-PAD_W-1:0];

	always @(posedge clk) begin
		if (m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
			if (due_pixels.size() == 0) begin
				flag_error($sformatf("unexpected result: pixel %0d row %0d col %0d last %0b",
					shown.pixel, shown.row, shown.col, m_axis_tlast));
			end else begin
				want = due_pixels.pop_front();
				if (shown.pixel !== want.pixel || shown.row !== want.row ||
						shown.col !== want.col || m_axis_tlast !== want.last ||
						m_axis_tdata[OUT_DATA_W-1:OUT_DATA_W-PAD_W] !== '0) begin
					flag_error($sformatf({"mismatch: expected pixel %0d row %0d col %0d last %0b,",
						" got pixel %0d row %0d col %0d last %0b pad %h"},
						want.pixel, want.row, want.col, want.last,
						shown.pixel, shown.row, shown.col, m_axis_tlast,
						m_axis_tdata[OUT_DATA_W-1:OUT_DATA_W-PAD_W]));
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb: errors");
			$finish;
		end
	end

	initial begin
		int i;
		int made;
		int phase;
		int n;
		int area;
		int nw;
		int nh;
		int lo;
		int hi;
		int t;
		bit near;
		bit at_origin;

		for (i = 0; i < 2 * LINE_MAX; i++) class_mem[i] = CODE_ZERO;
		for (i = 0; i < LINE_MAX; i++) strong_row[i] = 1'b0;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part
		for (i = 0; i < $size(directed_steps); i++) begin
			if (directed_steps[i].is_write) begin
				wait_drained();
				write_reg(directed_steps[i].reg_idx, CFG_DATA_W'(directed_steps[i].value));
			end else begin
				send_pixel(PIX_W'(directed_steps[i].value), directed_steps[i].fixed,
					directed_steps[i].fixed_pixel);
			end
		end

		// Oversized width, one row: the column must not wrap at the raw width's low bits
		wait_drained();
		gappy = 1'b1;
		lo = $urandom_range(0, 180);
		write_reg(REG_LOW_THR, CFG_DATA_W'(lo));
		write_reg(REG_HIGH_THR, CFG_DATA_W'($urandom_range(lo, 255)));
		write_reg(REG_IMG_WIDTH, {3'($urandom_range(0, 7)), 13'($urandom_range(4097, 4200))});
		write_reg(REG_IMG_HEIGHT, CFG_DATA_W'($urandom_range(0, 1)));
		repeat (WIDE_PIXELS) send_pixel(pick_pixel(1'b1), 1'b0, '0);

		// Random images
		made = 0;
		phase = 0;
		while (made < RANDOM_PIXELS) begin
			wait_drained();
			gappy = ($urandom_range(0, 2) != 0);

			lo = $urandom_range(0, 180);
			hi = $urandom_range(lo, 255);
			case ($urandom_range(0, 9))
				0: lo = 0;
				1: hi = 255;
				2: begin
					t = lo;
					lo = hi;
					hi = t;
				end
				3: lo = hi;
				default: ;
			endcase
			write_reg(REG_LOW_THR, {8'($urandom_range(0, 255)), 8'(lo)});
			write_reg(REG_HIGH_THR, {8'($urandom_range(0, 255)), 8'(hi)});

			// sizes; mid-image a change must push the position out of the image
			at_origin = (at_row == 0 && at_col == 0);
			if (phase == 0) begin
				nw = $urandom_range(1, 3);
				nh = 65535;
			end else begin
				case ($urandom_range(0, 9))
					0: begin
						nw = $urandom_range(0, 2);
						nh = $urandom_range(0, 6);
					end
					1: begin
						nw = $urandom_range(3, 10);
						nh = $urandom_range(0, 2);
					end
					2: begin
						nw = $urandom_range(2, 4);
						nh = 65535;
					end
					default: begin
						nw = $urandom_range(3, 10);
						nh = $urandom_range(3, 8);
					end
				endcase
				if (!at_origin && $urandom_range(0, 1) == 1) begin
					nw = eff_width_of(width_reg);
					nh = eff_height_of(height_reg);
					if (at_col > 0) nw = $urandom_range(0, at_col);
					else nh = $urandom_range(0, at_row);
				end
			end
			if (!at_origin && at_col < eff_width_of(IMG_W_W'(nw)) &&
					at_row < eff_height_of(ROW_W'(nh))) begin
				nw = width_reg;
				nh = height_reg;
			end
			write_reg(REG_IMG_WIDTH, {3'($urandom_range(0, 7)), 13'(nw)});
			write_reg(REG_IMG_HEIGHT, CFG_DATA_W'(nh));

			area = eff_width_of(width_reg) * eff_height_of(height_reg);
			if (phase == 0) n = 30;
			else if (area > 200) n = $urandom_range(1, 60);
			else if ($urandom_range(0, 3) == 0) n = $urandom_range(1, area);
			else n = area * $urandom_range(1, 2);

			// long output hold-off while pixels keep coming
			if (phase == 3 || $urandom_range(0, 14) == 0) begin
				hold_ask = 1'b1;
				n = n + 40;
			end

			near = ($urandom_range(0, 3) != 0);
			repeat (n) begin
				send_pixel(pick_pixel(near), 1'b0, '0);
				made++;
			end
			phase++;
		end

		wait_drained();
		if (error_count == 0) begin
			$display("tb: clean");
		end else begin
			$display("tb: errors");
		end
		$finish;
	end

endmodule

// ===== files.f =====
hdl/hti_pkg.sv
hdl/hti_cfg.sv
hdl/hti_scan.sv
hdl/hti_resolve.sv
hdl/hti_outbuf.sv
hdl/hysteresis_threshold_image.sv
hdl/hti_checker.sv
tb/tb.sv
